// ----- src/hgt_pkg.sv -----
// Shared widths, lane sizing helpers and the gamma threshold table generator.
package hgt_pkg;

  localparam int RAW_W          = 24;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC      = 8;
  localparam int PX_W           = 8;
  localparam int NUM_LANES      = 3;
  localparam int GAMMA_BITS_MAX = 16;
  localparam int THRESH_W       = GAMMA_BITS_MAX + 1;
  localparam int THRESH_N       = 1 << PX_W;
  localparam int BIG_W          = 192;
  // Multiply, saturate, index and the eight search steps of the gamma lookup.
  localparam int FIXED_STAGES   = 11;

  // Register select taken from paddr[2].
  localparam logic REG_GAIN     = 1'b0;
  localparam logic REG_TONEMAP  = 1'b1;

  typedef logic [THRESH_W-1:0] thresh_t;
  typedef thresh_t thresh_tab_t [THRESH_N];

  // Quotient bits the Reinhard divider has to produce.
  function automatic int div_steps(input int g, input int f);
    return (f < g) ? f : g;
  endfunction

  function automatic int lane_stages(input int g, input int f);
    return div_steps(g, f) + FIXED_STAGES;
  endfunction

  // Entry b is the smallest index i in [0, 2^g] with i^5 * 255^11 >= b^11 * 2^(5g),
  // so the display byte for index i is the largest b whose entry does not exceed i.
  // Evaluated once at elaboration.
  function automatic thresh_tab_t gamma_thresholds(input int g);
    thresh_tab_t         tab;
    logic [BIG_W-1:0]    p255;
    logic [BIG_W-1:0]    bpow;
    logic [BIG_W-1:0]    ipow;
    logic [BIG_W-1:0]    rhs;
    int                  lo;
    int                  hi;
    int                  mid;
    p255 = BIG_W'(1);
    for (int k = 0; k < 11; k++) begin
      p255 = p255 * BIG_W'(255);
    end
    for (int b = 0; b < THRESH_N; b++) begin
      bpow = BIG_W'(1);
      for (int k = 0; k < 11; k++) begin
        bpow = bpow * BIG_W'(b);
      end
      rhs = bpow << (5 * g);
      lo  = 0;
      hi  = 1 << g;
      while (lo < hi) begin
        mid  = (lo + hi) >> 1;
        ipow = BIG_W'(1);
        for (int k = 0; k < 5; k++) begin
          ipow = ipow * BIG_W'(mid);
        end
        ipow = ipow * p255;
        if (ipow >= rhs) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tab[b] = THRESH_W'(lo);
    end
    return tab;
  endfunction

endpackage

// ----- src/hdr_tonemap_gamma_rgb8_top.sv -----
// Top level of the HDR to 8-bit RGB tonemapper: register port, three lanes and output merge.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   pixel in | pix_valid / pix_stall      | red_in, green_in, blue_in (Q8.16)
//   result   | res_valid / res_stall      | red_out, green_out, blue_out
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One pixel is taken every clock while pix_stall is low; the pipeline depth follows the
// one-quotient-bit-per-stage Reinhard divider.
// Reset clears the valid pipeline, the output and skid valid flags and the two registers.
// A stalled result holds; the lanes keep moving until one more pixel sits in the skid
// register, and pix_stall rises only then.
module hdr_tonemap_gamma_rgb8_top
  import hgt_pkg::*;
#(
  parameter int GAMMA_TABLE_BITS = 10,
  parameter int INPUT_FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic [RAW_W-1:0] red_in,
  input  logic [RAW_W-1:0] green_in,
  input  logic [RAW_W-1:0] blue_in,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [PX_W-1:0]  red_out,
  output logic [PX_W-1:0]  green_out,
  output logic [PX_W-1:0]  blue_out
);

  localparam int STAGES = lane_stages(GAMMA_TABLE_BITS, INPUT_FRAC_BITS);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  logic [GAIN_W-1:0] exposure_gain;
  logic              tonemap_enable;
  logic              reg_sel;
  logic              adv;
  logic [RAW_W-1:0]  lane_raw [NUM_LANES];
  logic [PX_W-1:0]   lane_px  [NUM_LANES];
  logic [PX_W-1:0]   res_px   [NUM_LANES];

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain  <= GAIN_RESET;
      tonemap_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_GAIN:    exposure_gain  <= pwdata[GAIN_W-1:0];
        REG_TONEMAP: tonemap_enable <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GAIN:    prdata = {{(32 - GAIN_W){1'b0}}, exposure_gain};
      REG_TONEMAP: prdata = {31'b0, tonemap_enable};
      default:     prdata = '0;
    endcase
  end

  assign lane_raw[0] = red_in;
  assign lane_raw[1] = green_in;
  assign lane_raw[2] = blue_in;

  for (genvar n = 0; n < NUM_LANES; n++) begin : g_lane
    hgt_lane #(
      .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS),
      .INPUT_FRAC_BITS  (INPUT_FRAC_BITS)
    ) u_lane (
      .clk            (clk),
      .adv            (adv),
      .exposure_gain  (exposure_gain),
      .tonemap_enable (tonemap_enable),
      .raw            (lane_raw[n]),
      .px             (lane_px[n])
    );
  end

  hgt_merge #(
    .STAGES (STAGES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .adv       (adv),
    .lane_px   (lane_px),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_px    (res_px)
  );

  assign red_out   = res_px[0];
  assign green_out = res_px[1];
  assign blue_out  = res_px[2];

endmodule

// ----- src/hgt_lane.sv -----
// One colour channel: exposure multiply, Reinhard divider, clamp and gamma lookup.
module hgt_lane
  import hgt_pkg::*;
#(
  parameter int GAMMA_TABLE_BITS = 10,
  parameter int INPUT_FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [GAIN_W-1:0] exposure_gain,
  input  logic              tonemap_enable,
  input  logic [RAW_W-1:0]  raw,
  output logic [PX_W-1:0]   px
);

  localparam int Q      = div_steps(GAMMA_TABLE_BITS, INPUT_FRAC_BITS);
  localparam int IDX_W  = GAMMA_TABLE_BITS + 1;
  localparam int DIV_W  = RAW_W + 1;
  localparam int PROD_W = RAW_W + GAIN_W;
  localparam int SCL_W  = PROD_W - GAIN_FRAC;
  localparam logic [DIV_W-1:0] ONE = DIV_W'(1) << INPUT_FRAC_BITS;
  localparam thresh_tab_t THRESH = gamma_thresholds(GAMMA_TABLE_BITS);

  logic [PROD_W-1:0] prod;
  logic [SCL_W-1:0]  scaled;
  logic [RAW_W-1:0]  sat;

  logic [DIV_W-1:0]  rem [Q];
  logic [DIV_W-1:0]  dvs [Q];
  logic [Q-1:0]      quo [Q+1];
  logic [RAW_W-1:0]  cc  [Q+1];

  logic [DIV_W-1:0]  clamped;
  logic [IDX_W-1:0]  idx_nt;
  logic [IDX_W-1:0]  idx_tm;

  logic [IDX_W-1:0]  gidx [PX_W];
  logic [PX_W-1:0]   gb   [PX_W+1];

  // Exposure gain.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PROD_W'(raw) * PROD_W'(exposure_gain);
    end
  end

  assign scaled = prod[PROD_W-1:GAIN_FRAC];
  assign sat    = (|scaled[SCL_W-1:RAW_W]) ? '1 : scaled[RAW_W-1:0];

  // The dividend is c * 2^Q; its top part c is already below the divisor c + 1.0.
  always_ff @(posedge clk) begin
    if (adv) begin
      cc[0]  <= sat;
      rem[0] <= {1'b0, sat};
      dvs[0] <= {1'b0, sat} + ONE;
      quo[0] <= '0;
    end
  end

  for (genvar j = 0; j < Q; j++) begin : g_div
    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;

    assign shifted = {rem[j], 1'b0};
    assign diff    = shifted - {1'b0, dvs[j]};
    assign ge      = shifted >= {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (adv) begin
        quo[j+1] <= {quo[j][Q-2:0], ge};
        cc[j+1]  <= cc[j];
      end
    end

    if (j < Q - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[j+1] <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
          dvs[j+1] <= dvs[j];
        end
      end
    end
  end

  assign clamped = ({1'b0, cc[Q]} > ONE) ? ONE : {1'b0, cc[Q]};
  assign idx_tm  = IDX_W'(quo[Q]) << (GAMMA_TABLE_BITS - Q);

  if (INPUT_FRAC_BITS >= GAMMA_TABLE_BITS) begin : g_idx_down
    assign idx_nt = IDX_W'(clamped >> (INPUT_FRAC_BITS - GAMMA_TABLE_BITS));
  end else begin : g_idx_up
    assign idx_nt = IDX_W'(clamped[INPUT_FRAC_BITS:0]) << (GAMMA_TABLE_BITS - INPUT_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gidx[0] <= tonemap_enable ? idx_tm : idx_nt;
      gb[0]   <= '0;
    end
  end

  // Binary search for the largest byte whose threshold the index reaches, one bit a stage.
  for (genvar k = 0; k < PX_W; k++) begin : g_gamma
    logic [PX_W-1:0] cand;
    logic            hit;

    assign cand = gb[k] | (PX_W'(1) << (PX_W - 1 - k));
    assign hit  = THRESH[cand] <= THRESH_W'(gidx[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        gb[k+1] <= hit ? cand : gb[k];
      end
    end

    if (k < PX_W - 1) begin : g_idx_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          gidx[k+1] <= gidx[k];
        end
      end
    end
  end

  assign px = gb[PX_W];

endmodule

// ----- src/hgt_merge.sv -----
// Pipeline valid tracking, output register and one-pixel skid buffer across the lanes.
module hgt_merge
  import hgt_pkg::*;
#(
  parameter int STAGES = 21
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_stall,
  output logic            adv,
  input  logic [PX_W-1:0] lane_px [NUM_LANES],
  output logic            res_valid,
  input  logic            res_stall,
  output logic [PX_W-1:0] res_px  [NUM_LANES]
);

  logic [STAGES-1:0] vld;
  logic              skid_valid;
  logic [PX_W-1:0]   skid_px [NUM_LANES];
  logic              out_take;

  // The lanes only freeze once the skid stage holds a pixel.
  assign adv       = !skid_valid;
  assign pix_stall = skid_valid;
  assign out_take  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], pix_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid  <= vld[STAGES-1];
      end
    end else if (vld[STAGES-1] && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  for (genvar n = 0; n < NUM_LANES; n++) begin : g_px
    always_ff @(posedge clk) begin
      if (out_take) begin
        res_px[n] <= skid_valid ? skid_px[n] : lane_px[n];
      end
      if (!out_take && !skid_valid) begin
        skid_px[n] <= lane_px[n];
      end
    end
  end

endmodule

// ----- src/hgt_checker.sv -----
// Port-level checks for the tonemapper top level, bound to it.
module hgt_checker
  import hgt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready,
  input logic             pix_stall,
  input logic             res_valid,
  input logic             res_stall,
  input logic [PX_W-1:0]  red_out,
  input logic [PX_W-1:0]  green_out,
  input logic [PX_W-1:0]  blue_out
);

  // Reset empties the output and the skid stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !pix_stall)
    else $error("result or stall still set after reset");

  // Input is only held off while a finished pixel waits at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("input stalled with an empty output");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("stalled result changed");

  // A register read straight after a write returns what was written.
  a_gain_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_GAIN)
      ##1 (psel && !pwrite && paddr[2] == REG_GAIN)
      |-> prdata == {16'b0, $past(pwdata[15:0])})
    else $error("exposure gain read back wrong");

  a_tonemap_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_TONEMAP)
      ##1 (psel && !pwrite && paddr[2] == REG_TONEMAP)
      |-> prdata == {31'b0, $past(pwdata[0])})
    else $error("tonemap enable read back wrong");

endmodule

bind hdr_tonemap_gamma_rgb8_top hgt_checker u_hgt_checker (.*);

// ----- bench/hdr_tonemap_gamma_rgb8_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the HDR tonemap and gamma RGB8 pixel pipeline.
module hdr_tonemap_gamma_rgb8_top_tb;
  import hgt_pkg::*;

  localparam int LUT_BITS = 10;
  localparam int FRAC_BITS = 16;
  localparam int LUT_SIZE = (1 << LUT_BITS) + 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES = 8;
  localparam int PHASE_PIXELS = 64;
  localparam logic [2:0] ADDR_EXPOSURE_GAIN = 3'd0;
  localparam logic [2:0] ADDR_TONEMAP_ENABLE = 3'd4;
  localparam logic [15:0] GAIN_UNITY = 16'd256;
  localparam logic [15:0] GAIN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [PX_W-1:0] r;
    logic [PX_W-1:0] g;
    logic [PX_W-1:0] b;
  } rgb8_t;

  typedef struct packed {
    logic [15:0]      gain;
    logic             tm;
    logic [RAW_W-1:0] r;
    logic [RAW_W-1:0] g;
    logic [RAW_W-1:0] b;
    logic             known;
    rgb8_t            want;
  } vector_t;

  // Rows with a typed result are the obvious ones: black, full scale, zero gain and saturation.
  localparam int VECTORS = 18;
  localparam vector_t DIRECTED [VECTORS] = '{
    '{16'd256,   1'b0, 24'h000000, 24'h000000, 24'h000000, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b0, 24'h010000, 24'h010000, 24'h010000, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd256,   1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd256,   1'b0, 24'h000040, 24'h00003F, 24'h008000, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b0, 24'h00FFC0, 24'h00FFBF, 24'h000001, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b0, 24'hAAAAAA, 24'h555555, 24'h00FFFF, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b1, 24'h000000, 24'h000000, 24'h000000, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b1, 24'h010000, 24'hFFFFFF, 24'h000001, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd256,   1'b1, 24'h00FF00, 24'h7FFFFF, 24'h000100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd0,     1'b0, 24'hFFFFFF, 24'h123456, 24'h000001, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'd0,     1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'hFFFF,  1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'hFFFF,  1'b0, 24'h000001, 24'h000100, 24'h000200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'hFFFF,  1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'hFFFF,  1'b1, 24'h000001, 24'h000101, 24'h0F0F0F, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd1,     1'b1, 24'hFFFFFF, 24'h800000, 24'h000100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'd1,     1'b0, 24'hFFFFFF, 24'h010000, 24'h00FFFF, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{16'h8000,  1'b0, 24'h5A5A5A, 24'hA5A5A5, 24'h000080, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid = 1'b0;
  logic pix_stall;
  logic [RAW_W-1:0] red_in = '0;
  logic [RAW_W-1:0] green_in = '0;
  logic [RAW_W-1:0] blue_in = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [PX_W-1:0] red_out;
  logic [PX_W-1:0] green_out;
  logic [PX_W-1:0] blue_out;

  logic [PX_W-1:0] gamma_lut [LUT_SIZE];
  rgb8_t pending_bytes [$];
  logic [15:0] cur_gain = GAIN_UNITY;
  logic cur_tm = 1'b0;
  bit calm = 1'b0;
  int hold = 0;
  int failures = 0;
  int checked_pixels = 0;
  int reg_writes = 0;

  hdr_tonemap_gamma_rgb8_top #(
    .GAMMA_TABLE_BITS(LUT_BITS),
    .INPUT_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Byte b is chosen for index i when b^11 * 2^(5G) <= i^5 * 255^11, the exact form of
  // 255 * (i / 2^G)^(1/2.2). The byte never falls as the index rises, so one walk suffices.
  function automatic void build_gamma_lut();
    logic [191:0] byte_pow [256];
    logic [191:0] p255;
    logic [191:0] lhs;
    logic [191:0] t;
    int b;
    p255 = 192'd1;
    for (int k = 0; k < 11; k++) p255 = p255 * 192'd255;
    for (int v = 0; v < 256; v++) begin
      t = 192'd1;
      for (int k = 0; k < 11; k++) t = t * 192'(v);
      byte_pow[v] = t << (5 * LUT_BITS);
    end
    b = 0;
    for (int idx = 0; idx < LUT_SIZE; idx++) begin
      lhs = 192'd1;
      for (int k = 0; k < 5; k++) lhs = lhs * 192'(idx);
      lhs = lhs * p255;
      while (b < 255 && byte_pow[b + 1] <= lhs) b++;
      gamma_lut[idx] = PX_W'(b);
    end
  endfunction

  function automatic logic [PX_W-1:0] tonemap_channel(input logic [RAW_W-1:0] raw,
                                                      input logic [15:0] gain,
                                                      input logic tm);
    logic [63:0] c;
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS;
    c = (64'(raw) * 64'(gain)) >> GAIN_FRAC;
    if (c > 64'hFFFFFF) c = 64'hFFFFFF;
    if (tm) c = (c << FRAC_BITS) / (c + one);
    if (c > one) c = one;
    return gamma_lut[c >> (FRAC_BITS - LUT_BITS)];
  endfunction

  function automatic rgb8_t tonemap_pixel(input logic [RAW_W-1:0] r, g, b,
                                          input logic [15:0] gain, input logic tm);
    rgb8_t px;
    px.r = tonemap_channel(r, gain, tm);
    px.g = tonemap_channel(g, gain, tm);
    px.b = tonemap_channel(b, gain, tm);
    return px;
  endfunction

  // Half of the transfers go back to back, all of them in calm phases; the rest wait first.
  function automatic int draw_wait();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  // Radiance spread over all magnitudes, with extra weight just around 1.0.
  function automatic logic [RAW_W-1:0] random_radiance();
    logic [RAW_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = RAW_W'($urandom);
      1, 2: v = RAW_W'($urandom) >> $urandom_range(0, RAW_W - 1);
      default: v = RAW_W'(32'h0001_0000 + $urandom_range(0, 255) - 128);
    endcase
    return v;
  endfunction

  task automatic report(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_byte(input string lane, input logic [PX_W-1:0] want,
                            input logic [PX_W-1:0] got);
    if (got !== want)
      report($sformatf("Mismatch on %s at %0t: expected %0d, got %0d", lane, $realtime, want,
                       got));
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    pix_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Upper bits of each write are random; the block must ignore them.
  task automatic apply_setting(input logic [15:0] gain, input logic tm);
    wait_drain();
    write_reg(ADDR_EXPOSURE_GAIN, ($urandom & 32'hFFFF_0000) | 32'(gain));
    write_reg(ADDR_TONEMAP_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(tm));
    cur_gain = gain;
    cur_tm = tm;
  endtask

  task automatic send_pixel(input logic [RAW_W-1:0] r, g, b, input logic given,
                            input rgb8_t given_px);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (pix_stall);
    pending_bytes.push_back(given ? given_px : tonemap_pixel(r, g, b, cur_gain, cur_tm));
  endtask

  always @(posedge clk) begin : result_side
    int hold_next;
    rgb8_t want;
    if (rst) begin
      hold <= 0;
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_bytes.size() == 0) begin
          report($sformatf("Unexpected result at %0t: %0d %0d %0d", $realtime, red_out,
                           green_out, blue_out));
        end else begin
          want = pending_bytes.pop_front();
          check_byte("red_out", want.r, red_out);
          check_byte("green_out", want.g, green_out);
          check_byte("blue_out", want.b, blue_out);
        end
        checked_pixels++;
        hold_next = draw_wait();
      end else begin
        hold_next = (hold > 0) ? hold - 1 : 0;
      end
      hold <= hold_next;
      res_stall <= (hold_next != 0);
    end
  end

  initial begin
    logic [15:0] gain;
    logic tm;
    build_gamma_lut();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].gain != cur_gain || DIRECTED[i].tm != cur_tm)
        apply_setting(DIRECTED[i].gain, DIRECTED[i].tm);
      send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].known,
                 DIRECTED[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin gain = GAIN_MAX; tm = 1'b1; end
        1: begin gain = 16'd0; tm = 1'b0; end
        2: begin gain = GAIN_UNITY; tm = 1'b1; end
        default: begin
          gain = 16'($urandom) >> $urandom_range(0, 15);
          tm = 1'($urandom);
        end
      endcase
      apply_setting(gain, tm);
      calm = (phase == 3 || phase == 6);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // Let the whole pipeline empty once with no register change.
        if (phase == 4 && n == PHASE_PIXELS / 2) wait_drain();
        send_pixel(random_radiance(), random_radiance(), random_radiance(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    wait_drain();
    $display("Checked %0d pixels over %0d register writes, gain 0 to 65535, tonemap on and off.",
             checked_pixels, reg_writes);
    $display("Failures counted: %0d", failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hgt_pkg.sv
src/hgt_lane.sv
src/hgt_merge.sv
src/hdr_tonemap_gamma_rgb8_top.sv
src/hgt_checker.sv
bench/hdr_tonemap_gamma_rgb8_top_tb.sv
